[sv/i2cm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the I2C master byte engine.
// Used by every module of the block; depends on nothing.
package i2cm_pkg;

    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_W-1:0] HALF_PERIOD_RST  = 16'd100;
    localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST  = 16'd10;
    localparam logic [CFG_W-1:0] TIMEOUT_UNIT_RST = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_UNIT = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    // One classified tick as it waits in the queue.
    typedef struct packed {
        cmd_t              kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] half_period;
        logic [CFG_W-1:0] ack_timeout;
        logic [CFG_W-1:0] timeout_unit;
    } cfg_t;

endpackage

[sv/i2cm_front.sv]
`timescale 1ns / 1ps
// Front end: unpacks an input transfer and classifies its command.
// Depends on i2cm_pkg.
module i2cm_front
(
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [i2cm_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             push_valid,
    input  logic                             push_ready,
    output i2cm_pkg::item_t                  push_item
);

    i2cm_pkg::cmd_t kind;

    // Fold unknown codes into no command.
    always_comb
    begin
        case (s_axis_tuser)
            i2cm_pkg::CMD_START: kind = i2cm_pkg::CMD_START;
            i2cm_pkg::CMD_STOP:  kind = i2cm_pkg::CMD_STOP;
            i2cm_pkg::CMD_WRITE: kind = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::CMD_READ:  kind = i2cm_pkg::CMD_READ;
            default:             kind = i2cm_pkg::CMD_NONE;
        endcase
    end

    always_comb
    begin
        push_item.kind     = kind;
        push_item.tx_byte  = s_axis_tdata[i2cm_pkg::BYTE_W-1:0];
        push_item.send_ack = s_axis_tdata[i2cm_pkg::BYTE_W];
        push_item.sda_in   = s_axis_tdata[i2cm_pkg::BYTE_W+1];
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

[sv/i2cm_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified ticks between the front end and the engine.
// Depends on i2cm_pkg.
module i2cm_queue
#(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  i2cm_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output i2cm_pkg::item_t pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2cm_pkg::item_t store [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/i2cm_back.sv]
`timescale 1ns / 1ps
// Back end: the SCL/SDA phase sequencer, one queued tick per cycle unless
// the output is stalled, and the output register. Depends on i2cm_pkg.
module i2cm_back
#(
    parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  i2cm_pkg::cfg_t                   cfg,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  i2cm_pkg::item_t                  pop_item,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [i2cm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int EXT_W = (COUNT_WIDTH > i2cm_pkg::CFG_W) ? COUNT_WIDTH : i2cm_pkg::CFG_W;

    // Phase positions within each sequence.
    localparam logic [4:0] STEP_FIRST     = 5'd0;
    localparam logic [4:0] STEP_COND_END  = 5'd4;
    localparam logic [4:0] STEP_WR_BITEND = 5'd24;
    localparam logic [4:0] STEP_WR_SCLHI  = 5'd25;
    localparam logic [4:0] STEP_ACK_WAIT  = 5'd26;
    localparam logic [4:0] STEP_AFTER_ACK = 5'd27;
    localparam logic [4:0] STEP_RD_BITEND = 5'd16;
    localparam logic [4:0] STEP_RD_SCLHI  = 5'd17;
    localparam logic [4:0] STEP_RD_SCLLO  = 5'd18;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_OK,
        RES_TIMEOUT
    } res_t;

    i2cm_pkg::cmd_t                cmd_reg, cmd_next;
    logic [4:0]                    step_reg, step_next;
    logic [COUNT_WIDTH-1:0]        pt_reg, pt_next;
    logic [COUNT_WIDTH-1:0]        ut_reg, ut_next;
    logic [i2cm_pkg::CFG_W-1:0]    tl_reg, tl_next;
    logic [i2cm_pkg::BYTE_W-1:0]   sb_reg, sb_next;
    logic [i2cm_pkg::BYTE_W-1:0]   rx_reg, rx_next;
    logic                          scl_reg, scl_next;
    logic                          sda_reg, sda_next;
    logic                          ack_reg, ack_next;
    logic                          out_valid_reg;
    logic [i2cm_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic                          fire;
    logic                          enter;
    logic                          eval;
    logic                          hold_load;
    logic [4:0]                    s_enter;
    logic [i2cm_pkg::CFG_W-1:0]    tl_eval;
    logic [COUNT_WIDTH-1:0]        pt_dec;
    logic [8:0]                    prod;
    logic [2:0]                    bit_q;
    logic [4:0]                    bit_r;
    res_t                          res;
    logic                          done;
    logic                          status;

    // Zero counts as one; saturate at the counter range.
    function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [i2cm_pkg::CFG_W-1:0] v);
        logic [EXT_W-1:0] ve;
        logic [EXT_W-1:0] vmax;
        ve   = EXT_W'(v);
        vmax = EXT_W'({COUNT_WIDTH{1'b1}});
        if (ve == '0)
        begin
            ve = EXT_W'(1);
        end
        if (ve > vmax)
        begin
            ve = vmax;
        end
        return ve[COUNT_WIDTH-1:0];
    endfunction

    assign pop_ready = !out_valid_reg || m_axis_tready;
    assign fire      = pop_valid && pop_ready;

    // Bit number of a write phase: s / 3 via multiply by 11, shift by 5.
    assign prod  = 9'(s_enter) * 9'd11;
    assign bit_q = prod[7:5];
    assign bit_r = s_enter - 5'(bit_q) * 5'd3;

    always_comb
    begin
        cmd_next  = cmd_reg;
        step_next = step_reg;
        pt_next   = pt_reg;
        ut_next   = ut_reg;
        tl_next   = tl_reg;
        sb_next   = sb_reg;
        rx_next   = rx_reg;
        scl_next  = scl_reg;
        sda_next  = sda_reg;
        ack_next  = ack_reg;
        enter     = 1'b0;
        eval      = 1'b0;
        hold_load = 1'b0;
        s_enter   = STEP_FIRST;
        tl_eval   = tl_reg;
        pt_dec    = '0;
        res       = RES_HOLD;

        if (cmd_reg == i2cm_pkg::CMD_NONE)
        begin
            if (pop_item.kind != i2cm_pkg::CMD_NONE)
            begin
                cmd_next  = pop_item.kind;
                step_next = STEP_FIRST;
                sb_next   = (pop_item.kind == i2cm_pkg::CMD_WRITE) ? pop_item.tx_byte : '0;
                ack_next  = pop_item.send_ack;
                enter     = 1'b1;
            end
        end
        else if (cmd_reg == i2cm_pkg::CMD_WRITE && step_reg == STEP_ACK_WAIT)
        begin
            if (ut_reg != '0)
            begin
                ut_next = ut_reg - 1'b1;
                if (ut_reg == COUNT_WIDTH'(1))
                begin
                    tl_eval = (tl_reg != '0) ? tl_reg - 1'b1 : tl_reg;
                    tl_next = tl_eval;
                    eval    = 1'b1;
                end
            end
            else
            begin
                eval = 1'b1;
            end
        end
        else
        begin
            pt_dec  = (pt_reg != '0) ? pt_reg - 1'b1 : '0;
            pt_next = pt_dec;
            if (pt_dec == '0)
            begin
                step_next = step_reg + 1'b1;
                s_enter   = step_reg + 1'b1;
                enter     = 1'b1;
            end
        end

        // Line action of the phase being entered.
        if (enter)
        begin
            hold_load = 1'b1;
            case (cmd_next)
                i2cm_pkg::CMD_START:
                begin
                    if (s_enter >= STEP_COND_END)
                    begin
                        res       = RES_OK;
                        hold_load = 1'b0;
                    end
                    else
                    begin
                        case (s_enter[1:0])
                            2'd0:    sda_next = 1'b1;
                            2'd1:    scl_next = 1'b1;
                            2'd2:    sda_next = 1'b0;
                            default: scl_next = 1'b0;
                        endcase
                    end
                end
                i2cm_pkg::CMD_STOP:
                begin
                    if (s_enter >= STEP_COND_END)
                    begin
                        res       = RES_OK;
                        hold_load = 1'b0;
                    end
                    else
                    begin
                        case (s_enter[1:0])
                            2'd0:    sda_next = 1'b0;
                            2'd1:    scl_next = 1'b1;
                            2'd2:    sda_next = 1'b1;
                            default: ;
                        endcase
                    end
                end
                i2cm_pkg::CMD_WRITE:
                begin
                    if (s_enter < STEP_WR_BITEND)
                    begin
                        if (bit_r == 5'd0)
                        begin
                            sda_next = sb_next[~bit_q];
                        end
                        else if (bit_r == 5'd1)
                        begin
                            scl_next = 1'b1;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                        end
                    end
                    else if (s_enter == STEP_WR_BITEND)
                    begin
                        sda_next = 1'b1;
                    end
                    else if (s_enter == STEP_WR_SCLHI)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (s_enter == STEP_ACK_WAIT)
                    begin
                        tl_next   = cfg.ack_timeout;
                        tl_eval   = cfg.ack_timeout;
                        ut_next   = '0;
                        eval      = 1'b1;
                        hold_load = 1'b0;
                    end
                    else if (s_enter == STEP_AFTER_ACK)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        res       = RES_OK;
                        hold_load = 1'b0;
                    end
                end
                i2cm_pkg::CMD_READ:
                begin
                    if (s_enter < STEP_RD_BITEND)
                    begin
                        if (!s_enter[0])
                        begin
                            sda_next = 1'b1;
                            scl_next = 1'b1;
                        end
                        else
                        begin
                            sb_next  = {sb_next[i2cm_pkg::BYTE_W-2:0], pop_item.sda_in};
                            scl_next = 1'b0;
                        end
                    end
                    else if (s_enter == STEP_RD_BITEND)
                    begin
                        sda_next = !ack_next;
                    end
                    else if (s_enter == STEP_RD_SCLHI)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (s_enter == STEP_RD_SCLLO)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        sda_next  = 1'b1;
                        rx_next   = sb_next;
                        res       = RES_OK;
                        hold_load = 1'b0;
                    end
                end
                default:
                begin
                    hold_load = 1'b0;
                end
            endcase
            if (hold_load)
            begin
                pt_next = load_count(cfg.half_period);
            end
        end

        // Sample SDA for the slave ACK.
        if (eval)
        begin
            if (!pop_item.sda_in)
            begin
                scl_next  = 1'b0;
                step_next = STEP_AFTER_ACK;
                pt_next   = load_count(cfg.half_period);
            end
            else if (cfg.ack_timeout == '0)
            begin
                ut_next = '0;
            end
            else if (tl_eval == '0)
            begin
                scl_next = 1'b0;
                res      = RES_TIMEOUT;
            end
            else
            begin
                ut_next = load_count(cfg.timeout_unit);
            end
        end

        done   = (res != RES_HOLD);
        status = (res == RES_TIMEOUT);
        if (done)
        begin
            cmd_next  = i2cm_pkg::CMD_NONE;
            step_next = STEP_FIRST;
            ut_next   = '0;
            pt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= i2cm_pkg::CMD_NONE;
            step_reg      <= '0;
            pt_reg        <= '0;
            ut_reg        <= '0;
            tl_reg        <= '0;
            sb_reg        <= '0;
            rx_reg        <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                cmd_reg      <= cmd_next;
                step_reg     <= step_next;
                pt_reg       <= pt_next;
                ut_reg       <= ut_next;
                tl_reg       <= tl_next;
                sb_reg       <= sb_next;
                rx_reg       <= rx_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                ack_reg      <= ack_next;
                out_data_reg <= {3'b000, rx_next, status, done,
                                 cmd_next != i2cm_pkg::CMD_NONE, sda_next, scl_next};
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[sv/i2c_master_byte_engine_core.sv]
`timescale 1ns / 1ps
// I2C master byte engine, top level: configuration registers and the
// front end, queue and sequencer. Depends on i2cm_pkg and all i2cm_ modules.
//
// Each input transfer is one tick of the I2C engine and yields exactly one
// output transfer with the SCL/SDA drive levels, busy, done, status and the
// last received byte. The block takes one transfer per clock while the
// queue has room: a tick is popped into the sequencer, whose counters and
// line levels update once per popped tick, and its result is registered.
// With neither side stalling, the result passes the queue and the output
// register before it is presented. A queue (four entries by default)
// decouples input from the sequencer; a waiting result holds the sequencer,
// and the output register is refilled in the same cycle it drains. Commands
// arrive in tuser and are taken only while idle; codes 5 to 7 are treated as
// no command. Write the configuration registers only while no tick sits in
// the queue or waits at the output; a write during a command takes effect at
// the next count load or ACK sample.
module i2c_master_byte_engine_core
#(
    parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tx_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
    input  logic [i2cm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command[2:0]
    input  logic [i2cm_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], status[4],
    // rx_byte[12:5], zero[15:13]
    output logic [i2cm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    i2cm_pkg::cfg_t  cfg_reg;
    logic            push_valid;
    logic            push_ready;
    i2cm_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    i2cm_pkg::item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period  <= i2cm_pkg::HALF_PERIOD_RST;
            cfg_reg.ack_timeout  <= i2cm_pkg::ACK_TIMEOUT_RST;
            cfg_reg.timeout_unit <= i2cm_pkg::TIMEOUT_UNIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cm_pkg::REG_HALF_PERIOD:  cfg_reg.half_period  <= cfg_data;
                i2cm_pkg::REG_ACK_TIMEOUT:  cfg_reg.ack_timeout  <= cfg_data;
                i2cm_pkg::REG_TIMEOUT_UNIT: cfg_reg.timeout_unit <= cfg_data;
                default: ;
            endcase
        end
    end

    i2cm_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    i2cm_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    i2cm_back
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
